[sv/cia_pkg.sv]
// Package: word types, function codes and register map for the CIA timer block.
package cia_pkg;

   // Function codes carried in the request word
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_EVENT = 2'd3;

   // Register map
   localparam logic [3:0] REG_PRA   = 4'd0;
   localparam logic [3:0] REG_PRB   = 4'd1;
   localparam logic [3:0] REG_DDRA  = 4'd2;
   localparam logic [3:0] REG_DDRB  = 4'd3;
   localparam logic [3:0] REG_TA_LO = 4'd4;
   localparam logic [3:0] REG_TA_HI = 4'd5;
   localparam logic [3:0] REG_TB_LO = 4'd6;
   localparam logic [3:0] REG_TB_HI = 4'd7;
   localparam logic [3:0] REG_EV_LO = 4'd8;
   localparam logic [3:0] REG_EV_MD = 4'd9;
   localparam logic [3:0] REG_EV_HI = 4'd10;
   localparam logic [3:0] REG_NONE  = 4'd11;
   localparam logic [3:0] REG_SDR   = 4'd12;
   localparam logic [3:0] REG_ICR   = 4'd13;
   localparam logic [3:0] REG_CRA   = 4'd14;
   localparam logic [3:0] REG_CRB   = 4'd15;

   // Fixed read values of the direction registers and the unused slot
   localparam logic [7:0] DDRA_UNIT_A = 8'h03;
   localparam logic [7:0] DDRA_UNIT_B = 8'hc0;
   localparam logic [7:0] DDRB_UNIT_B = 8'hff;
   localparam logic [7:0] NONE_READ   = 8'hff;

   // Interrupt bits
   localparam logic [4:0] IRQ_TA    = 5'h01;
   localparam logic [4:0] IRQ_TB    = 5'h02;
   localparam logic [4:0] IRQ_ALARM = 5'h04;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] reg_index;
      logic [7:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
   } rsp_word_type;

endpackage

[sv/cia_timer_tod_interrupt_block.sv]
// Top level: CIA timers, event counter, interrupt register and port latches.
//
// Usage
//   req channel (valid/ready) carries one word per bus access or tick: a
//   register read, a register write, a timer tick or an event-counter tick.
//   rsp channel (valid/ready) returns exactly one word per request word:
//   read data (zero for non-reads), the interrupt line and both port
//   output registers as they stand after that word.
//   csr port writes unit_is_b (second-unit personality) with no handshake;
//   write it only while the block is idle.
// Timing and throughput
//   All state updates at the accept edge; the response word is registered
//   and valid in the next cycle. One word per cycle while rsp_ready is high:
//   the single response register is refilled in the same cycle it is drained.
// Stall
//   While rsp_valid is high and rsp_ready low, req_ready drops, the
//   response word holds and no state changes.
// Reset
//   Synchronous, active high. Timer counts and latches go to all ones,
//   port A to 0xff, everything else to zero; no response is pending.
module cia_timer_tod_interrupt_block #(
   parameter int TIMER_WIDTH = 16,
   parameter int EVENT_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cia_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cia_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   localparam logic [TIMER_WIDTH-1:0] T_ONE  = TIMER_WIDTH'(1);
   localparam logic [TIMER_WIDTH-1:0] T_ONES = '1;
   localparam logic [EVENT_WIDTH-1:0] E_ONE  = EVENT_WIDTH'(1);

   // State registers
   logic                   unit_b_ff;
   logic [TIMER_WIDTH-1:0] ta_count_ff, ta_count_in;
   logic [TIMER_WIDTH-1:0] tb_count_ff, tb_count_in;
   logic [TIMER_WIDTH-1:0] ta_reload_ff, ta_reload_in;
   logic [TIMER_WIDTH-1:0] tb_reload_ff, tb_reload_in;
   logic [7:0]             ctrl_a_ff, ctrl_a_in;
   logic [7:0]             ctrl_b_ff, ctrl_b_in;
   logic [7:0]             pend_ff, pend_in;
   logic [4:0]             enable_ff, enable_in;
   logic [EVENT_WIDTH-1:0] ev_count_ff, ev_count_in;
   logic [EVENT_WIDTH-1:0] ev_alarm_ff, ev_alarm_in;
   logic [EVENT_WIDTH-1:0] ev_rhold_ff, ev_rhold_in;
   logic                   ev_held_ff, ev_held_in;
   logic [EVENT_WIDTH-1:0] ev_whold_ff, ev_whold_in;
   logic                   ev_wpend_ff, ev_wpend_in;
   logic [7:0]             pra_ff, pra_in;
   logic [7:0]             prb_ff, prb_in;
   logic [7:0]             ddrb_ff, ddrb_in;
   logic [7:0]             sdr_ff, sdr_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   cia_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic       accept;
   logic       do_raise;
   logic [7:0] rd_data;

   // Zero latch loads as the full count
   function automatic logic [TIMER_WIDTH-1:0] load_value(input logic [TIMER_WIDTH-1:0] v);
      return (v == '0) ? T_ONES : v;
   endfunction

   // Replace one byte of a timer value; bytes above the width drop out
   function automatic logic [TIMER_WIDTH-1:0] put_timer(input logic [TIMER_WIDTH-1:0] old,
                                                        input logic hi,
                                                        input logic [7:0] d);
      logic [31:0] ext;
      ext = 32'(old);
      if (hi) ext[15:8] = d;
      else    ext[7:0]  = d;
      return ext[TIMER_WIDTH-1:0];
   endfunction

   // Replace byte 0..2 of an event value
   function automatic logic [EVENT_WIDTH-1:0] put_event(input logic [EVENT_WIDTH-1:0] old,
                                                        input logic [1:0] pos,
                                                        input logic [7:0] d);
      logic [31:0] ext;
      ext = 32'(old);
      case (pos)
         2'd0:    ext[7:0]   = d;
         2'd1:    ext[15:8]  = d;
         default: ext[23:16] = d;
      endcase
      return ext[EVENT_WIDTH-1:0];
   endfunction

   function automatic logic [7:0] timer_byte(input logic [TIMER_WIDTH-1:0] v, input logic hi);
      logic [31:0] ext;
      ext = 32'(v);
      return hi ? ext[15:8] : ext[7:0];
   endfunction

   function automatic logic [7:0] event_byte(input logic [EVENT_WIDTH-1:0] v,
                                             input logic [1:0] pos);
      logic [31:0] ext;
      ext = 32'(v);
      case (pos)
         2'd0:    return ext[7:0];
         2'd1:    return ext[15:8];
         default: return ext[23:16];
      endcase
   endfunction

   // Output register drains and refills in the same cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Next state: one word worth of register updates, in the order the
   // hardware applies them (timer A, then its cascade into B, then B alone).
   always_comb begin
      ta_count_in  = ta_count_ff;
      tb_count_in  = tb_count_ff;
      ta_reload_in = ta_reload_ff;
      tb_reload_in = tb_reload_ff;
      ctrl_a_in    = ctrl_a_ff;
      ctrl_b_in    = ctrl_b_ff;
      pend_in      = pend_ff;
      enable_in    = enable_ff;
      ev_count_in  = ev_count_ff;
      ev_alarm_in  = ev_alarm_ff;
      ev_rhold_in  = ev_rhold_ff;
      ev_held_in   = ev_held_ff;
      ev_whold_in  = ev_whold_ff;
      ev_wpend_in  = ev_wpend_ff;
      pra_in       = pra_ff;
      prb_in       = prb_ff;
      ddrb_in      = ddrb_ff;
      sdr_in       = sdr_ff;
      do_raise     = 1'b0;
      rd_data      = 8'h00;

      case (req_word.func)
         cia_pkg::FUNC_READ: begin
            case (req_word.reg_index)
               cia_pkg::REG_PRA:   rd_data = pra_ff;
               cia_pkg::REG_PRB:   rd_data = prb_ff;
               cia_pkg::REG_DDRA:  rd_data = unit_b_ff ? cia_pkg::DDRA_UNIT_B
                                                       : cia_pkg::DDRA_UNIT_A;
               cia_pkg::REG_DDRB:  rd_data = unit_b_ff ? cia_pkg::DDRB_UNIT_B : ddrb_ff;
               cia_pkg::REG_TA_LO: rd_data = timer_byte(ta_count_ff, 1'b0);
               cia_pkg::REG_TA_HI: rd_data = timer_byte(ta_count_ff, 1'b1);
               cia_pkg::REG_TB_LO: rd_data = timer_byte(tb_count_ff, 1'b0);
               cia_pkg::REG_TB_HI: rd_data = timer_byte(tb_count_ff, 1'b1);
               cia_pkg::REG_EV_LO: begin
                  // low byte read releases the read hold
                  rd_data    = event_byte(ev_held_ff ? ev_rhold_ff : ev_count_ff, 2'd0);
                  ev_held_in = 1'b0;
               end
               cia_pkg::REG_EV_MD:
                  rd_data = event_byte(ev_held_ff ? ev_rhold_ff : ev_count_ff, 2'd1);
               cia_pkg::REG_EV_HI: begin
                  // high byte read freezes the count for the following reads
                  rd_data     = event_byte(ev_count_ff, 2'd2);
                  ev_held_in  = 1'b1;
                  ev_rhold_in = ev_count_ff;
               end
               cia_pkg::REG_SDR:   rd_data = sdr_ff;
               cia_pkg::REG_ICR: begin
                  rd_data = pend_ff;
                  pend_in = 8'h00;
               end
               cia_pkg::REG_CRA:   rd_data = ctrl_a_ff;
               cia_pkg::REG_CRB:   rd_data = ctrl_b_ff;
               default:            rd_data = cia_pkg::NONE_READ;
            endcase
         end

         cia_pkg::FUNC_WRITE: begin
            case (req_word.reg_index)
               cia_pkg::REG_PRA:   pra_in = req_word.write_data;
               cia_pkg::REG_PRB:   prb_in = req_word.write_data;
               cia_pkg::REG_DDRB:  if (!unit_b_ff) ddrb_in = req_word.write_data;
               cia_pkg::REG_TA_LO:
                  ta_reload_in = put_timer(ta_reload_ff, 1'b0, req_word.write_data);
               cia_pkg::REG_TA_HI: begin
                  ta_reload_in = put_timer(ta_reload_ff, 1'b1, req_word.write_data);
                  // stopped or one-shot: load now, one-shot also starts
                  if (ctrl_a_ff[3] || !ctrl_a_ff[0]) begin
                     ta_count_in = load_value(ta_reload_in);
                     if (ctrl_a_ff[3]) ctrl_a_in[0] = 1'b1;
                  end
               end
               cia_pkg::REG_TB_LO:
                  tb_reload_in = put_timer(tb_reload_ff, 1'b0, req_word.write_data);
               cia_pkg::REG_TB_HI: begin
                  tb_reload_in = put_timer(tb_reload_ff, 1'b1, req_word.write_data);
                  if (ctrl_b_ff[3] || !ctrl_b_ff[0]) begin
                     tb_count_in = load_value(tb_reload_in);
                     if (ctrl_b_ff[3]) ctrl_b_in[0] = 1'b1;
                  end
               end
               cia_pkg::REG_EV_LO: begin
                  ev_wpend_in = 1'b0;
                  ev_whold_in = put_event(ev_whold_ff, 2'd0, req_word.write_data);
                  if (ctrl_b_ff[7]) ev_alarm_in = ev_whold_in;
                  else              ev_count_in = ev_whold_in;
                  if (ev_count_in == ev_alarm_in) begin
                     pend_in[4:0] = pend_in[4:0] | cia_pkg::IRQ_ALARM;
                     do_raise     = 1'b1;
                  end
               end
               cia_pkg::REG_EV_MD: begin
                  ev_wpend_in = 1'b1;
                  ev_whold_in = put_event(ev_whold_ff, 2'd1, req_word.write_data);
               end
               cia_pkg::REG_EV_HI: begin
                  ev_wpend_in = 1'b1;
                  ev_whold_in = put_event(ev_whold_ff, 2'd2, req_word.write_data);
               end
               cia_pkg::REG_SDR:   sdr_in = req_word.write_data;
               cia_pkg::REG_ICR: begin
                  // bit 7 selects set or clear of the mask bits
                  if (req_word.write_data[7]) enable_in = enable_ff | req_word.write_data[4:0];
                  else                        enable_in = enable_ff & ~req_word.write_data[4:0];
                  do_raise = 1'b1;
               end
               cia_pkg::REG_CRA: begin
                  ctrl_a_in = req_word.write_data;
                  if (req_word.write_data[4]) begin
                     ta_count_in  = load_value(ta_reload_ff);
                     ctrl_a_in[4] = 1'b0;
                  end
               end
               cia_pkg::REG_CRB: begin
                  ctrl_b_in = req_word.write_data;
                  if (req_word.write_data[4]) begin
                     tb_count_in  = load_value(tb_reload_ff);
                     ctrl_b_in[4] = 1'b0;
                  end
               end
               default: ;
            endcase
         end

         cia_pkg::FUNC_TICK: begin
            if (ctrl_a_ff[0]) begin
               ta_count_in = ta_count_ff - T_ONE;
               if (ta_count_in == '0) begin
                  ta_count_in = load_value(ta_reload_ff);
                  // B in cascade mode counts A underflows
                  if (ctrl_b_ff[6] && ctrl_b_ff[0]) begin
                     tb_count_in = tb_count_ff - T_ONE;
                     if (tb_count_in == '0) begin
                        tb_count_in = load_value(tb_reload_ff);
                        if (ctrl_b_ff[3]) ctrl_b_in[0] = 1'b0;
                        pend_in[4:0] = pend_in[4:0] | cia_pkg::IRQ_TB;
                     end
                  end
                  if (ctrl_a_ff[3]) ctrl_a_in[0] = 1'b0;
                  pend_in[4:0] = pend_in[4:0] | cia_pkg::IRQ_TA;
                  do_raise     = 1'b1;
               end
            end
            if (!ctrl_b_in[6] && ctrl_b_in[0]) begin
               tb_count_in = tb_count_in - T_ONE;
               if (tb_count_in == '0) begin
                  tb_count_in = load_value(tb_reload_ff);
                  if (ctrl_b_in[3]) ctrl_b_in[0] = 1'b0;
                  pend_in[4:0] = pend_in[4:0] | cia_pkg::IRQ_TB;
                  do_raise     = 1'b1;
               end
            end
         end

         default: begin
            // event tick, ignored while a partial write waits for its low byte
            if (!ev_wpend_ff) begin
               ev_count_in = ev_count_ff + E_ONE;
               if (ev_count_in == ev_alarm_ff) begin
                  pend_in[4:0] = pend_in[4:0] | cia_pkg::IRQ_ALARM;
                  do_raise     = 1'b1;
               end
            end
         end
      endcase

      // Master bit follows any request raise or mask update
      if (do_raise && (|(pend_in[4:0] & enable_in))) pend_in[7] = 1'b1;

      rsp_word_in.read_data  = rd_data;
      rsp_word_in.irq_line   = |(pend_in[4:0] & enable_in);
      rsp_word_in.port_a_out = pra_in;
      rsp_word_in.port_b_out = prb_in;

      if (accept)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_b_ff    <= 1'b0;
         ta_count_ff  <= T_ONES;
         tb_count_ff  <= T_ONES;
         ta_reload_ff <= T_ONES;
         tb_reload_ff <= T_ONES;
         ctrl_a_ff    <= 8'h00;
         ctrl_b_ff    <= 8'h00;
         pend_ff      <= 8'h00;
         enable_ff    <= 5'h00;
         ev_count_ff  <= '0;
         ev_alarm_ff  <= '0;
         ev_rhold_ff  <= '0;
         ev_held_ff   <= 1'b0;
         ev_whold_ff  <= '0;
         ev_wpend_ff  <= 1'b0;
         pra_ff       <= 8'hff;
         prb_ff       <= 8'h00;
         ddrb_ff      <= 8'h00;
         sdr_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) unit_b_ff <= csr_write_data;
         if (accept) begin
            ta_count_ff  <= ta_count_in;
            tb_count_ff  <= tb_count_in;
            ta_reload_ff <= ta_reload_in;
            tb_reload_ff <= tb_reload_in;
            ctrl_a_ff    <= ctrl_a_in;
            ctrl_b_ff    <= ctrl_b_in;
            pend_ff      <= pend_in;
            enable_ff    <= enable_in;
            ev_count_ff  <= ev_count_in;
            ev_alarm_ff  <= ev_alarm_in;
            ev_rhold_ff  <= ev_rhold_in;
            ev_held_ff   <= ev_held_in;
            ev_whold_ff  <= ev_whold_in;
            ev_wpend_ff  <= ev_wpend_in;
            pra_ff       <= pra_in;
            prb_ff       <= prb_in;
            ddrb_ff      <= ddrb_in;
            sdr_ff       <= sdr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) rsp_word_ff <= rsp_word_in;
   end

   // An unmasked pending request always has the master bit set
   a_master_bit: assert property (@(posedge clock) disable iff (reset)
      (|(pend_ff[4:0] & enable_ff)) |-> pend_ff[7])
      else $error("unmasked request without master bit");

   // Unused request bits never set
   a_pend_unused: assert property (@(posedge clock) disable iff (reset)
      pend_ff[6:5] == 2'b00)
      else $error("unused interrupt bits set");

   // Force load strobes are never stored
   a_force_load: assert property (@(posedge clock) disable iff (reset)
      !ctrl_a_ff[4] && !ctrl_b_ff[4])
      else $error("force load bit stored");

   // No word accepted while a stalled response would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("response overwritten under stall");

   // Irq line on the response matches state after that word
   a_irq_line: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_word_ff.irq_line == (|(pend_ff[4:0] & enable_ff))))
      else $error("irq line out of step with state");

endmodule

[dv/cia_timer_tod_interrupt_block_tb.sv]
// Self-checking testbench for the CIA timer, event counter and interrupt block.
module cia_timer_tod_interrupt_block_tb;

   // Control register bits (cra / crb), the set/clear bit of an icr write and the icr summary bit
   localparam int CR_START     = 0;
   localparam int CR_ONE_SHOT  = 3;
   localparam int CR_LOAD      = 4;
   localparam int CRB_COUNT_TA = 6;
   localparam int CRB_ALARM    = 7;
   localparam int ICR_SET      = 7;
   localparam int ICR_ANY      = 7;

   localparam logic [15:0] TIMER_ALL_ONES = 16'hffff;
   localparam int          WATCHDOG_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   cia_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   cia_pkg::rsp_word_type rsp_word;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data = 1'b0;

   cia_timer_tod_interrupt_block DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the chip state, advanced once per accepted req word
   // ------------------------------------------------------------------
   bit          second_unit;
   logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
   logic [7:0]  cra, crb, icr_data;
   logic [4:0]  icr_mask;
   logic [23:0] tod_count, tod_alarm, tod_read_latch, tod_write_latch;
   bit          tod_read_frozen, tod_write_busy;
   logic [7:0]  pra, prb, ddrb, sdr;

   function automatic void reset_shadow();
      second_unit     = 1'b0;
      ta_count        = TIMER_ALL_ONES;
      tb_count        = TIMER_ALL_ONES;
      ta_latch        = TIMER_ALL_ONES;
      tb_latch        = TIMER_ALL_ONES;
      cra             = '0;
      crb             = '0;
      icr_data        = '0;
      icr_mask        = '0;
      tod_count       = '0;
      tod_alarm       = '0;
      tod_read_latch  = '0;
      tod_write_latch = '0;
      tod_read_frozen = 1'b0;
      tod_write_busy  = 1'b0;
      pra             = 8'hff;
      prb             = '0;
      ddrb            = '0;
      sdr             = '0;
   endfunction

   // A zero latch loads as the full count.
   function automatic logic [15:0] reload_of(logic [15:0] latch);
      return (latch == '0) ? TIMER_ALL_ONES : latch;
   endfunction

   // Any enabled pending source sets the summary bit; only an icr read clears it.
   function automatic void post_irq(logic [4:0] source);
      icr_data[4:0] = icr_data[4:0] | source;
      if ((icr_data[4:0] & icr_mask) != '0)
         icr_data[ICR_ANY] = 1'b1;
   endfunction

   function automatic void underflow_b();
      tb_count = reload_of(tb_latch);
      if (crb[CR_ONE_SHOT])
         crb[CR_START] = 1'b0;
      post_irq(cia_pkg::IRQ_TB);
   endfunction

   // Timer A underflow also clocks timer B when B is started and chained.
   function automatic void underflow_a();
      ta_count = reload_of(ta_latch);
      if (crb[CRB_COUNT_TA] && crb[CR_START]) begin
         tb_count = tb_count - 16'd1;
         if (tb_count == '0)
            underflow_b();
      end
      if (cra[CR_ONE_SHOT])
         cra[CR_START] = 1'b0;
      post_irq(cia_pkg::IRQ_TA);
   endfunction

   function automatic void count_timers();
      if (cra[CR_START]) begin
         ta_count = ta_count - 16'd1;
         if (ta_count == '0)
            underflow_a();
      end
      if (crb[CR_START] && !crb[CRB_COUNT_TA]) begin
         tb_count = tb_count - 16'd1;
         if (tb_count == '0)
            underflow_b();
      end
   endfunction

   // Event ticks are dropped while a mid/high write waits for its low byte.
   function automatic void count_tod();
      if (!tod_write_busy) begin
         tod_count = tod_count + 24'd1;
         if (tod_alarm == tod_count)
            post_irq(cia_pkg::IRQ_ALARM);
      end
   endfunction

   function automatic logic [7:0] read_register(logic [3:0] idx);
      logic [7:0] value;
      value = cia_pkg::NONE_READ;
      case (idx)
         cia_pkg::REG_PRA:   value = pra;
         cia_pkg::REG_PRB:   value = prb;
         cia_pkg::REG_DDRA:  value = second_unit ? cia_pkg::DDRA_UNIT_B
                                                 : cia_pkg::DDRA_UNIT_A;
         cia_pkg::REG_DDRB:  value = second_unit ? cia_pkg::DDRB_UNIT_B : ddrb;
         cia_pkg::REG_TA_LO: value = ta_count[7:0];
         cia_pkg::REG_TA_HI: value = ta_count[15:8];
         cia_pkg::REG_TB_LO: value = tb_count[7:0];
         cia_pkg::REG_TB_HI: value = tb_count[15:8];
         cia_pkg::REG_EV_LO: begin
            value = tod_read_frozen ? tod_read_latch[7:0] : tod_count[7:0];
            tod_read_frozen = 1'b0;
         end
         cia_pkg::REG_EV_MD:
            value = tod_read_frozen ? tod_read_latch[15:8] : tod_count[15:8];
         cia_pkg::REG_EV_HI: begin
            tod_read_frozen = 1'b1;
            tod_read_latch  = tod_count;
            value           = tod_count[23:16];
         end
         cia_pkg::REG_SDR:   value = sdr;
         cia_pkg::REG_ICR: begin
            value    = icr_data;
            icr_data = '0;
         end
         cia_pkg::REG_CRA:   value = cra;
         cia_pkg::REG_CRB:   value = crb;
         default:            value = cia_pkg::NONE_READ;
      endcase
      return value;
   endfunction

   function automatic void write_register(logic [3:0] idx, logic [7:0] d);
      logic [7:0] ctrl;
      ctrl = d;
      case (idx)
         cia_pkg::REG_PRA:   pra = d;
         cia_pkg::REG_PRB:   prb = d;
         cia_pkg::REG_DDRB:  if (!second_unit) ddrb = d;
         cia_pkg::REG_TA_LO: ta_latch[7:0] = d;
         cia_pkg::REG_TA_HI: begin
            // high byte loads a stopped or one-shot timer; one-shot also starts it
            ta_latch[15:8] = d;
            if (cra[CR_ONE_SHOT] || !cra[CR_START]) begin
               ta_count = reload_of(ta_latch);
               if (cra[CR_ONE_SHOT])
                  cra[CR_START] = 1'b1;
            end
         end
         cia_pkg::REG_TB_LO: tb_latch[7:0] = d;
         cia_pkg::REG_TB_HI: begin
            tb_latch[15:8] = d;
            if (crb[CR_ONE_SHOT] || !crb[CR_START]) begin
               tb_count = reload_of(tb_latch);
               if (crb[CR_ONE_SHOT])
                  crb[CR_START] = 1'b1;
            end
         end
         cia_pkg::REG_EV_LO: begin
            tod_write_busy       = 1'b0;
            tod_write_latch[7:0] = d;
            if (crb[CRB_ALARM])
               tod_alarm = tod_write_latch;
            else
               tod_count = tod_write_latch;
            if (tod_count == tod_alarm)
               post_irq(cia_pkg::IRQ_ALARM);
         end
         cia_pkg::REG_EV_MD: begin
            tod_write_busy        = 1'b1;
            tod_write_latch[15:8] = d;
         end
         cia_pkg::REG_EV_HI: begin
            tod_write_busy         = 1'b1;
            tod_write_latch[23:16] = d;
         end
         cia_pkg::REG_SDR:   sdr = d;
         cia_pkg::REG_ICR: begin
            if (d[ICR_SET])
               icr_mask = icr_mask | d[4:0];
            else
               icr_mask = icr_mask & ~d[4:0];
            post_irq('0);
         end
         cia_pkg::REG_CRA: begin
            // force load is a strobe, never stored
            if (ctrl[CR_LOAD]) begin
               ta_count      = reload_of(ta_latch);
               ctrl[CR_LOAD] = 1'b0;
            end
            cra = ctrl;
         end
         cia_pkg::REG_CRB: begin
            if (ctrl[CR_LOAD]) begin
               tb_count      = reload_of(tb_latch);
               ctrl[CR_LOAD] = 1'b0;
            end
            crb = ctrl;
         end
         default: ;  // ddra and the unused slot ignore writes
      endcase
   endfunction

   function automatic cia_pkg::rsp_word_type predict_response(cia_pkg::req_word_type w);
      cia_pkg::rsp_word_type r;
      r = '0;
      case (w.func)
         cia_pkg::FUNC_READ:  r.read_data = read_register(w.reg_index);
         cia_pkg::FUNC_WRITE: write_register(w.reg_index, w.write_data);
         cia_pkg::FUNC_TICK:  count_timers();
         default:             count_tod();
      endcase
      r.irq_line   = |(icr_data[4:0] & icr_mask);
      r.port_a_out = pra;
      r.port_b_out = prb;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driver: pops pending words, sends them in bursts with random gaps,
   // and predicts each word at its accept edge.
   // ------------------------------------------------------------------
   cia_pkg::req_word_type pending_words[$];
   cia_pkg::rsp_word_type expected_rsps[$];
   int                    queued_count;
   int                    burst_left;
   int                    gap_left;
   int                    errors;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_word   <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(predict_response(req_word));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_word  <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 24);
               burst_left--;
               // a quarter of the bursts run straight into the next one
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: rsp_ready follows a pattern picked by the top two bits of
   // an 8-bit stall counter (always ready, 3 of 4, coin flip, 1 of 5);
   // each accepted rsp word is checked against the oldest prediction.
   // ------------------------------------------------------------------
   logic [7:0]            stall_cycle;
   cia_pkg::rsp_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_cycle = '0;
      end else begin
         stall_cycle = stall_cycle + 8'd1;
         case (stall_cycle[7:6])
            2'd0:    rsp_ready <= 1'b1;
            2'd1:    rsp_ready <= (stall_cycle[1:0] != 2'd0);
            2'd2:    rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (stall_cycle % 5 == 0);
         endcase
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected rsp word, expected none, actual %p", $time, rsp_word);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_word.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_word.read_data);
                  errors++;
               end
               if (rsp_word.irq_line !== want.irq_line) begin
                  $display("%0t: irq_line expected %b actual %b",
                           $time, want.irq_line, rsp_word.irq_line);
                  errors++;
               end
               if (rsp_word.port_a_out !== want.port_a_out) begin
                  $display("%0t: port_a_out expected %h actual %h",
                           $time, want.port_a_out, rsp_word.port_a_out);
                  errors++;
               end
               if (rsp_word.port_b_out !== want.port_b_out) begin
                  $display("%0t: port_b_out expected %h actual %h",
                           $time, want.port_b_out, rsp_word.port_b_out);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog: too long without a handshake on either channel ends the run.
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("cia_timer_tod_interrupt_block_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_item(logic [1:0] f, logic [3:0] idx, logic [7:0] d);
      cia_pkg::req_word_type w;
      w.func       = f;
      w.reg_index  = idx;
      w.write_data = d;
      pending_words.push_back(w);
      queued_count++;
   endtask

   // Status is sampled at the falling edge, clear of the driver's updates.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   // unit_is_b only changes with nothing in flight
   task automatic set_unit(bit unit_b);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= unit_b;
      second_unit      = unit_b;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed setup sequences with random content, plus noise.
   task automatic add_random_traffic(int count);
      int         stop_at;
      logic [7:0] d;
      logic [7:0] hi;
      logic [7:0] md;
      stop_at = queued_count + count;
      while (queued_count < stop_at) begin
         case ($urandom_range(0, 11))
            0, 1: begin
               // timer A with a short latch, then ticks through underflows
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_LO, 8'($urandom_range(0, 6)));
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_HI,
                         ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00);
               d = 8'($urandom);
               d[CR_START] = ($urandom_range(0, 4) != 0);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRA, d);
               repeat ($urandom_range(1, 12))
                  push_item(cia_pkg::FUNC_TICK, 4'($urandom), 8'($urandom));
               push_item(cia_pkg::FUNC_READ,
                         $urandom_range(0, 1) ? cia_pkg::REG_ICR : cia_pkg::REG_TA_LO,
                         8'h00);
            end
            2, 3: begin
               // timer B, free running or chained to timer A
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TB_LO, 8'($urandom_range(0, 4)));
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TB_HI,
                         ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00);
               d = 8'($urandom);
               d[CR_START] = ($urandom_range(0, 4) != 0);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRB, d);
               if ($urandom_range(0, 1)) begin
                  push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_LO,
                            8'($urandom_range(0, 3)));
                  push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_HI, 8'h00);
                  push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRA,
                            {4'h0, 1'($urandom), 3'b001});
               end
               repeat ($urandom_range(1, 14))
                  push_item(cia_pkg::FUNC_TICK, 4'($urandom), 8'($urandom));
               push_item(cia_pkg::FUNC_READ,
                         $urandom_range(0, 1) ? cia_pkg::REG_ICR : cia_pkg::REG_TB_LO,
                         8'h00);
            end
            4, 5: begin
               // alarm a few counts ahead of the counter, sometimes near wrap
               hi = $urandom_range(0, 1) ? 8'hff : 8'($urandom);
               md = $urandom_range(0, 1) ? 8'hff : 8'($urandom);
               d  = 8'($urandom);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRB, {1'b1, 7'($urandom)});
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_HI, hi);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_MD, md);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_LO,
                         d + 8'($urandom_range(0, 5)));
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRB, {1'b0, 7'($urandom)});
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_HI, hi);
               push_item(cia_pkg::FUNC_EVENT, 4'($urandom), 8'($urandom));
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_MD, md);
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_LO, d);
               repeat ($urandom_range(1, 8))
                  push_item(cia_pkg::FUNC_EVENT, 4'($urandom), 8'($urandom));
               push_item(cia_pkg::FUNC_READ, cia_pkg::REG_EV_HI, 8'h00);
               push_item(cia_pkg::FUNC_EVENT, 4'($urandom), 8'($urandom));
               push_item(cia_pkg::FUNC_READ, cia_pkg::REG_EV_MD, 8'h00);
               push_item(cia_pkg::FUNC_READ, cia_pkg::REG_EV_LO, 8'h00);
               push_item(cia_pkg::FUNC_READ, cia_pkg::REG_ICR, 8'h00);
            end
            6: begin
               push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_ICR, 8'($urandom));
               if ($urandom_range(0, 1))
                  push_item(cia_pkg::FUNC_READ, cia_pkg::REG_ICR, 8'($urandom));
            end
            7: begin
               repeat ($urandom_range(1, 4))
                  push_item(cia_pkg::FUNC_READ, 4'($urandom), 8'($urandom));
            end
            8, 9: begin
               repeat ($urandom_range(1, 8))
                  push_item($urandom_range(0, 1) ? cia_pkg::FUNC_TICK : cia_pkg::FUNC_EVENT,
                            4'($urandom), 8'($urandom));
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  push_item(2'($urandom), 4'($urandom), 8'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      reset_shadow();
      queued_count = 0;
      errors       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first unit, directed words
      set_unit(1'b0);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_PRA, 8'h00);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_PRA, 8'hff);    // reads the stored value
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_PRB, 8'hff);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_DDRA, 8'hff);  // ignored
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_DDRA, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_DDRB, 8'ha5);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_DDRB, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_NONE, 8'h55);  // unused slot, reads ff
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_NONE, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_ICR, 8'h9f);   // enable every source
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_LO, 8'h02);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_HI, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_CRA, 8'h19);   // start, one-shot, load
      push_item(cia_pkg::FUNC_TICK, 4'h0, 8'h00);
      push_item(cia_pkg::FUNC_TICK, 4'hf, 8'hff);                // underflow raises timer A
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_ICR, 8'h1f);   // mask off; summary stays
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_ICR, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_LO, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_TA_HI, 8'h00); // zero latch: all ones
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_TA_HI, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_HI, 8'h12);
      push_item(cia_pkg::FUNC_EVENT, 4'h0, 8'h00);               // dropped: low byte pending
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_EV_LO, 8'hff);
      push_item(cia_pkg::FUNC_EVENT, 4'h0, 8'h00);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_EV_HI, 8'h00);
      add_random_traffic(80);
      wait_drained();                             // sender holds until all words are back
      add_random_traffic(70);

      // second unit: fixed direction registers
      set_unit(1'b1);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_DDRA, 8'h00);
      push_item(cia_pkg::FUNC_WRITE, cia_pkg::REG_DDRB, 8'h5a);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_DDRB, 8'h00);
      push_item(cia_pkg::FUNC_READ, cia_pkg::REG_PRA, 8'h00);
      add_random_traffic(120);

      set_unit(1'b0);
      add_random_traffic(70);
      set_unit(1'b1);
      add_random_traffic(60);

      wait_drained();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("cia_timer_tod_interrupt_block_tb: PASS");
      else
         $display("cia_timer_tod_interrupt_block_tb: FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/cia_pkg.sv
sv/cia_timer_tod_interrupt_block.sv
dv/cia_timer_tod_interrupt_block_tb.sv
